// File: rtl/fva_pkg.sv
package fva_pkg;

    localparam int MASK_W  = 32;
    localparam int VOICE_W = 5;
    localparam int CH_W    = 4;
    localparam int NOTE_W  = 7;
    localparam int AGE_W   = 7;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_ALL_OFF  = 2'd2;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_RELEASE      = 2'd1;
    localparam logic [1:0] ST_NOT_PLAYABLE = 2'd2;
    localparam logic [1:0] ST_NO_VOICE     = 2'd3;

    localparam logic [AGE_W-1:0] AGE_MAX = 7'd127;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_SCAN,
        DP_FREE,
        DP_AGE,
        DP_PREP,
        DP_FIND,
        DP_WR_LO,
        DP_WR_HI,
        DP_NOFREE
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       vel_zero;
        logic       playable;
        logic       pair;
        logic       scan_done;
        logic       hit;
        logic       find_last;
        logic       best_vld;
    } t_dp_status;

endpackage

// File: rtl/fva_ctrl.sv
module fva_ctrl
    import fva_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_REL,
        S_FREE,
        S_AGE,
        S_PREP,
        S_FIND,
        S_PICK,
        S_WR1,
        S_ALL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = DP_IDLE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_st.op)
                    OP_NOTE_ON, OP_NOTE_OFF: n_state = S_REL;
                    OP_ALL_OFF:              n_state = S_ALL;
                    default:                 n_state = S_DONE;
                endcase
            end
            S_REL: begin
                o_cmd = DP_SCAN;
                if (i_st.scan_done) begin
                    if (i_st.hit) begin
                        n_state = S_FREE;
                    end else if (i_st.op == OP_NOTE_OFF) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_FREE: begin
                o_cmd   = DP_FREE;
                n_state = S_AGE;
            end
            S_AGE: begin
                o_cmd   = DP_AGE;
                n_state = (i_st.op == OP_NOTE_OFF) ? S_DONE : S_PREP;
            end
            S_PREP: begin
                o_cmd   = DP_PREP;
                n_state = (i_st.vel_zero || !i_st.playable) ? S_DONE : S_FIND;
            end
            S_FIND: begin
                o_cmd = DP_FIND;
                if (i_st.find_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_st.best_vld) begin
                    o_cmd   = DP_WR_LO;
                    n_state = i_st.pair ? S_WR1 : S_DONE;
                end else begin
                    o_cmd   = DP_NOFREE;
                    n_state = S_DONE;
                end
            end
            S_WR1: begin
                o_cmd   = DP_WR_HI;
                n_state = S_DONE;
            end
            S_ALL: begin
                o_cmd = DP_SCAN;
                if (i_st.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
            r_valid <= (n_state == S_DONE);
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule

// File: rtl/fva_dp.sv
module fva_dp
    import fva_pkg::*;
#(
    parameter int VOICES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [1:0]          i_op,
    input  logic [CH_W-1:0]     i_channel,
    input  logic [NOTE_W-1:0]   i_note,
    input  logic [6:0]          i_velocity,
    input  logic                i_pair_mode,
    input  logic                i_playable,
    output t_dp_status          o_st,
    output logic [MASK_W-1:0]   o_key_off_mask,
    output logic [MASK_W-1:0]   o_key_on_mask,
    output logic [VOICE_W-1:0]  o_voice,
    output logic [1:0]          o_status
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MB = (VOICES < MASK_W) ? VOICES : MASK_W;
    localparam logic [IW-1:0] LAST = IW'(VOICES - 1);

    logic [CH_W+NOTE_W-1:0] mem [VOICES];
    logic [CH_W+NOTE_W-1:0] r_rd_data;

    logic                r_busy   [VOICES];
    logic                r_paired [VOICES];
    logic [AGE_W-1:0]    r_age    [VOICES];

    logic [1:0]          r_op;
    logic [CH_W-1:0]     r_ch;
    logic [NOTE_W-1:0]   r_nt;
    logic                r_vel_zero;
    logic                r_play;
    logic                r_pair;

    logic [IW-1:0]       r_idx;
    logic                r_issue;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_hit;

    logic [IW-1:0]       r_best;
    logic [AGE_W-1:0]    r_best_age;
    logic                r_best_vld;

    logic [MASK_W-1:0]   r_off;
    logic [MASK_W-1:0]   r_on;
    logic [VOICE_W-1:0]  r_voice;
    logic [1:0]          r_status;

    logic                owner_eq;
    logic                rel_hit;
    logic                all_hit;
    logic                scan_done;
    logic [IW-1:0]       partner;
    logic                pair_ok;
    logic                cand;
    logic                better;
    logic [IW-1:0]       waddr;
    logic                free_sel [VOICES];

    always_comb begin
        owner_eq  = r_cmp_vld && r_busy[r_cmp_idx]
                    && (r_rd_data[CH_W+NOTE_W-1:NOTE_W] == r_ch);
        rel_hit   = owner_eq && (r_rd_data[NOTE_W-1:0] == r_nt) && (r_op != OP_ALL_OFF);
        all_hit   = owner_eq && (r_op == OP_ALL_OFF);
        scan_done = r_cmp_vld && (rel_hit || (r_cmp_idx == LAST));

        partner = r_idx | IW'(1);
        pair_ok = !r_idx[0] && (partner <= LAST);
        cand    = !r_busy[r_idx] && (!r_pair || (pair_ok && !r_busy[partner]));
        better  = cand && (!r_best_vld || (r_age[r_idx] > r_best_age));

        waddr = (i_cmd == DP_WR_HI) ? (r_best | IW'(1)) : r_best;

        for (int j = 0; j < VOICES; j++) begin
            free_sel[j] = (IW'(j) == r_hit)
                          || (r_paired[r_hit] && ((IW'(j) >> 1) == (r_hit >> 1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd == DP_WR_LO) || (i_cmd == DP_WR_HI)) begin
            mem[waddr] <= {r_ch, r_nt};
        end
        r_rd_data <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < VOICES; j++) begin
                r_busy[j]   <= 1'b0;
                r_paired[j] <= 1'b0;
                r_age[j]    <= '0;
            end
            r_issue    <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            case (i_cmd)
                DP_LOAD: begin
                    r_op       <= i_op;
                    r_ch       <= i_channel;
                    r_nt       <= i_note;
                    r_vel_zero <= (i_velocity == '0);
                    r_play     <= i_playable;
                    r_pair     <= i_pair_mode;
                    r_idx      <= '0;
                    r_issue    <= 1'b1;
                    r_cmp_vld  <= 1'b0;
                    r_best_vld <= 1'b0;
                    r_off      <= '0;
                    r_on       <= '0;
                    r_voice    <= '0;
                    r_status   <= ST_OK;
                end
                DP_SCAN: begin
                    r_cmp_idx <= r_idx;
                    r_cmp_vld <= r_issue;
                    if (r_issue) begin
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                    if (rel_hit) begin
                        r_hit <= r_cmp_idx;
                    end
                    if (all_hit) begin
                        r_busy[r_cmp_idx] <= 1'b0;
                        for (int j = 0; j < MB; j++) begin
                            if (IW'(j) == r_cmp_idx) begin
                                r_off[j] <= 1'b1;
                            end
                        end
                    end
                end
                DP_FREE: begin
                    for (int j = 0; j < VOICES; j++) begin
                        if (free_sel[j]) begin
                            r_busy[j]   <= 1'b0;
                            r_paired[j] <= 1'b0;
                            r_age[j]    <= '0;
                        end
                    end
                    for (int j = 0; j < MB; j++) begin
                        if (free_sel[j]) begin
                            r_off[j] <= 1'b1;
                        end
                    end
                end
                DP_AGE: begin
                    for (int j = 0; j < VOICES; j++) begin
                        if (!r_busy[j] && (r_age[j] < AGE_MAX)) begin
                            r_age[j] <= r_age[j] + AGE_W'(1);
                        end
                    end
                end
                DP_PREP: begin
                    r_idx      <= '0;
                    r_best_vld <= 1'b0;
                    if (r_vel_zero) begin
                        r_status <= ST_RELEASE;
                    end else if (!r_play) begin
                        r_status <= ST_NOT_PLAYABLE;
                    end
                end
                DP_FIND: begin
                    if (better) begin
                        r_best     <= r_idx;
                        r_best_age <= r_age[r_idx];
                        r_best_vld <= 1'b1;
                    end
                    if (r_idx != LAST) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                DP_WR_LO, DP_WR_HI: begin
                    r_busy[waddr]   <= 1'b1;
                    r_paired[waddr] <= r_pair;
                    r_voice         <= VOICE_W'(r_best);
                    for (int j = 0; j < MB; j++) begin
                        if (IW'(j) == waddr) begin
                            r_on[j] <= 1'b1;
                        end
                    end
                end
                DP_NOFREE: begin
                    r_status <= ST_NO_VOICE;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_st.op        = r_op;
        o_st.vel_zero  = r_vel_zero;
        o_st.playable  = r_play;
        o_st.pair      = r_pair;
        o_st.scan_done = scan_done;
        o_st.hit       = rel_hit;
        o_st.find_last = (r_idx == LAST);
        o_st.best_vld  = r_best_vld;
    end

    assign o_key_off_mask = r_off;
    assign o_key_on_mask  = r_on;
    assign o_voice        = r_voice;
    assign o_status       = r_status;

endmodule

// File: rtl/fm_voice_allocator.sv
// Channel   Direction  Handshake              Fields
// event     in         start high, busy low   op, channel, note, velocity,
//                                             pair_mode, playable
// result    out        o_valid, one cycle     key_off_mask, key_on_mask, voice, status
//
// Each event gives one result beat. Its timing is set by the one-voice-a-cycle scans over
// the owner/note memory and, for a note-on, the ages.
// Reset is synchronous and frees every voice at once; no clearing pass follows.
// The receiver cannot stall the result beat; busy falls in the cycle after it.
module fm_voice_allocator
    import fva_pkg::*;
#(
    parameter int VOICES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_op,
    input  logic [CH_W-1:0]     i_channel,
    input  logic [NOTE_W-1:0]   i_note,
    input  logic [6:0]          i_velocity,
    input  logic                i_pair_mode,
    input  logic                i_playable,
    output logic                o_valid,
    output logic [MASK_W-1:0]   o_key_off_mask,
    output logic [MASK_W-1:0]   o_key_on_mask,
    output logic [VOICE_W-1:0]  o_voice,
    output logic [1:0]          o_status
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_st;

    fva_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (dp_st),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    fva_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_op           (i_op),
        .i_channel      (i_channel),
        .i_note         (i_note),
        .i_velocity     (i_velocity),
        .i_pair_mode    (i_pair_mode),
        .i_playable     (i_playable),
        .o_st           (dp_st),
        .o_key_off_mask (o_key_off_mask),
        .o_key_on_mask  (o_key_on_mask),
        .o_voice        (o_voice),
        .o_status       (o_status)
    );

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted event did not raise busy");

    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside an event");

    a_fail_no_keyon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> ((o_key_on_mask == '0) && (o_voice == '0)))
        else $error("failed note-on keyed a voice");

    a_keyon_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_key_on_mask != '0)) |-> (o_status == ST_OK))
        else $error("key-on with a failure status");
`endif

endmodule
